@@ rtl/prx_pkg.sv @@
package prx_pkg;

    // micro-operation codes of the shared multiplier sequence
    localparam logic [4:0] UOP_CX_A  = 5'd0;
    localparam logic [4:0] UOP_CX_B  = 5'd1;
    localparam logic [4:0] UOP_CY_A  = 5'd2;
    localparam logic [4:0] UOP_CY_B  = 5'd3;
    localparam logic [4:0] UOP_CZ_A  = 5'd4;
    localparam logic [4:0] UOP_CZ_B  = 5'd5;
    localparam logic [4:0] UOP_NSQ_X = 5'd6;
    localparam logic [4:0] UOP_NSQ_Y = 5'd7;
    localparam logic [4:0] UOP_NSQ_Z = 5'd8;
    localparam logic [4:0] UOP_NUM_X = 5'd9;
    localparam logic [4:0] UOP_NUM_Y = 5'd10;
    localparam logic [4:0] UOP_NUM_Z = 5'd11;
    localparam logic [4:0] UOP_SSQ_X = 5'd12;
    localparam logic [4:0] UOP_SSQ_Y = 5'd13;
    localparam logic [4:0] UOP_SSQ_Z = 5'd14;
    localparam logic [4:0] UOP_T0_LO = 5'd15;
    localparam logic [4:0] UOP_T0_HI = 5'd16;
    localparam logic [4:0] UOP_T1_LO = 5'd17;
    localparam logic [4:0] UOP_T1_HI = 5'd18;

    // quotient bits of the offset divider (offset never exceeds half width)
    localparam int DIV_QBITS = 26;

    // register indexes
    localparam logic [2:0] REG_UP_X  = 3'd0;
    localparam logic [2:0] REG_UP_Y  = 3'd1;
    localparam logic [2:0] REG_UP_Z  = 3'd2;
    localparam logic [2:0] REG_HALF  = 3'd3;
    localparam logic [2:0] REG_ANIM  = 3'd4;

    typedef struct packed {
        logic signed [17:0] up_x;
        logic signed [17:0] up_y;
        logic signed [17:0] up_z;
        logic [24:0]        half_width;
        logic [23:0]        anim_speed;
    } t_cfg;

    typedef struct packed {
        logic       take;
        logic       diff;
        logic       mul;
        logic       acc;
        logic       fix;
        logic       norm;
        logic       sq_start;
        logic       sq_take;
        logic       div_start;
        logic       div_take;
        logic       emit0;
        logic       emit1;
        logic [4:0] uop;
    } t_cmd;

    typedef struct packed {
        logic seen;
        logic last;
        logic norm_done;
        logic norm_zero;
        logic sq_busy;
        logic div_busy;
        logic out_free;
    } t_status;

endpackage

@@ rtl/prx_sqrt.sv @@
module prx_sqrt
    import prx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    output logic        o_busy,
    output logic [31:0] o_root
);

    logic [63:0] r_x, r_r, r_b;
    logic [63:0] n_x, n_r, w_sum;

    assign o_busy = |r_b;
    assign o_root = r_r[31:0];
    assign w_sum  = r_r + r_b;

    // one result bit per cycle
    always_comb begin
        if (r_x >= w_sum) begin
            n_x = r_x - w_sum;
            n_r = (r_r >> 1) + r_b;
        end else begin
            n_x = r_x;
            n_r = r_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b <= '0;
        end else if (i_start) begin
            r_b <= 64'h4000_0000_0000_0000;
        end else if (o_busy) begin
            r_b <= r_b >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_r <= '0;
        end else if (o_busy) begin
            r_x <= n_x;
            r_r <= n_r;
        end
    end

endmodule

@@ rtl/prx_div.sv @@
module prx_div
    import prx_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [55:0]          i_num,
    input  logic [31:0]          i_den,
    output logic                 o_busy,
    output logic [DIV_QBITS-1:0] o_quo
);

    localparam int CW = $clog2(DIV_QBITS + 1);

    logic [31:0]          r_rem, r_den;
    logic [DIV_QBITS-1:0] r_n, r_q;
    logic [CW-1:0]        r_cnt;
    logic [32:0]          w_rem2;
    logic                 w_ge;

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_q;
    assign w_rem2 = {r_rem, r_n[DIV_QBITS-1]};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(DIV_QBITS);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 32'(i_num[55:DIV_QBITS]);
            r_n   <= i_num[DIV_QBITS-1:0];
            r_den <= i_den;
            r_q   <= '0;
        end else if (o_busy) begin
            r_rem <= w_ge ? 32'(w_rem2 - {1'b0, r_den}) : w_rem2[31:0];
            r_n   <= {r_n[DIV_QBITS-2:0], 1'b0};
            r_q   <= {r_q[DIV_QBITS-2:0], w_ge};
        end
    end

endmodule

@@ rtl/prx_dp.sv @@
module prx_dp
    import prx_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    input  t_cfg         i_cfg,
    input  logic [95:0]  i_tdata,
    input  logic         i_tlast,
    input  logic         i_m_tready,
    output t_status      o_status,
    output logic         o_m_tvalid,
    output logic [223:0] o_m_tdata,
    output logic         o_m_tlast
);

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -34'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [30:0] tex_sat(input logic [63:0] t);
        logic [64:0] rnd;
        rnd = {1'b0, t} + 65'd32768;
        return (|rnd[64:47]) ? 31'h7FFF_FFFF : rnd[46:16];
    endfunction

    logic               r_seen, r_last;
    logic signed [31:0] r_held [3];
    logic signed [31:0] r_p [3];
    logic [39:0]        r_path, r_plen1;
    logic signed [32:0] r_d [3];
    logic signed [51:0] r_c [3];
    logic [50:0]        r_m [3];
    logic               r_neg [3];
    logic [30:0]        r_ms [3];
    logic [1:0]         r_s;
    logic signed [63:0] r_prod;
    logic [63:0]        r_acc, r_t;
    logic [30:0]        r_len;
    logic [55:0]        r_num;
    logic signed [26:0] r_off [3];
    logic [30:0]        r_tex0, r_tex1;
    logic               r_ovalid, r_olast;
    logic [223:0]       r_odata;

    logic signed [17:0] w_ux, w_uy, w_uz;
    logic signed [33:0] w_opa, w_opb;
    logic signed [67:0] w_prod;
    logic               w_any_hi, w_any29, w_mzero, w_czero, w_out_free;
    logic [32:0]        w_dmag [3];
    logic [1:0]         w_s;
    logic [31:0]        w_root;
    logic               w_sq_busy, w_div_busy;
    logic [DIV_QBITS-1:0] w_quo;
    logic [63:0]        w_t_hi;
    logic [33:0]        w_seglen;
    logic [40:0]        w_plen;
    logic [223:0]       w_pair0, w_pair1;

    // camera up, with the default when all zero
    always_comb begin
        w_ux = i_cfg.up_x;
        w_uy = i_cfg.up_y;
        w_uz = i_cfg.up_z;
        if (i_cfg.up_x == '0 && i_cfg.up_y == '0 && i_cfg.up_z == '0) begin
            w_uy = 18'sd65536;
        end
    end

    // shared multiplier operands
    always_comb begin
        unique case (i_cmd.uop)
            UOP_CX_A:  begin w_opa = 34'(r_d[1]); w_opb = 34'(w_uz); end
            UOP_CX_B:  begin w_opa = 34'(r_d[2]); w_opb = 34'(w_uy); end
            UOP_CY_A:  begin w_opa = 34'(r_d[2]); w_opb = 34'(w_ux); end
            UOP_CY_B:  begin w_opa = 34'(r_d[0]); w_opb = 34'(w_uz); end
            UOP_CZ_A:  begin w_opa = 34'(r_d[0]); w_opb = 34'(w_uy); end
            UOP_CZ_B:  begin w_opa = 34'(r_d[1]); w_opb = 34'(w_ux); end
            UOP_NSQ_X: begin w_opa = {4'b0, r_m[0][29:0]}; w_opb = {4'b0, r_m[0][29:0]}; end
            UOP_NSQ_Y: begin w_opa = {4'b0, r_m[1][29:0]}; w_opb = {4'b0, r_m[1][29:0]}; end
            UOP_NSQ_Z: begin w_opa = {4'b0, r_m[2][29:0]}; w_opb = {4'b0, r_m[2][29:0]}; end
            UOP_NUM_X: begin w_opa = {4'b0, r_m[0][29:0]}; w_opb = {9'b0, i_cfg.half_width}; end
            UOP_NUM_Y: begin w_opa = {4'b0, r_m[1][29:0]}; w_opb = {9'b0, i_cfg.half_width}; end
            UOP_NUM_Z: begin w_opa = {4'b0, r_m[2][29:0]}; w_opb = {9'b0, i_cfg.half_width}; end
            UOP_SSQ_X: begin w_opa = {3'b0, r_ms[0]}; w_opb = {3'b0, r_ms[0]}; end
            UOP_SSQ_Y: begin w_opa = {3'b0, r_ms[1]}; w_opb = {3'b0, r_ms[1]}; end
            UOP_SSQ_Z: begin w_opa = {3'b0, r_ms[2]}; w_opb = {3'b0, r_ms[2]}; end
            UOP_T0_LO: begin w_opa = {14'b0, r_path[19:0]}; w_opb = {10'b0, i_cfg.anim_speed}; end
            UOP_T0_HI: begin w_opa = {14'b0, r_path[39:20]}; w_opb = {10'b0, i_cfg.anim_speed}; end
            UOP_T1_LO: begin w_opa = {14'b0, r_plen1[19:0]}; w_opb = {10'b0, i_cfg.anim_speed}; end
            UOP_T1_HI: begin w_opa = {14'b0, r_plen1[39:20]}; w_opb = {10'b0, i_cfg.anim_speed}; end
            default:   begin w_opa = '0; w_opb = '0; end
        endcase
    end

    assign w_prod = w_opa * w_opb;
    assign w_t_hi = r_t + {r_prod[43:0], 20'b0};

    assign w_any_hi = (|r_m[0][50:30]) | (|r_m[1][50:30]) | (|r_m[2][50:30]);
    assign w_any29  = (|r_m[0][50:29]) | (|r_m[1][50:29]) | (|r_m[2][50:29]);
    assign w_mzero  = (r_m[0] == '0) && (r_m[1] == '0) && (r_m[2] == '0);
    assign w_czero  = (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_dmag[i] = r_d[i][32] ? 33'(-r_d[i]) : 33'(r_d[i]);
        end
        if (w_dmag[0][32] | w_dmag[1][32] | w_dmag[2][32]) begin
            w_s = 2'd2;
        end else if (w_dmag[0][31] | w_dmag[1][31] | w_dmag[2][31]) begin
            w_s = 2'd1;
        end else begin
            w_s = 2'd0;
        end
    end

    assign w_seglen = 34'(w_root) << r_s;
    assign w_plen   = {1'b0, r_path} + {7'b0, w_seglen};

    prx_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sq_start),
        .i_x     (r_acc),
        .o_busy  (w_sq_busy),
        .o_root  (w_root)
    );

    prx_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num),
        .i_den   ({1'b0, r_len}),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    // vertex pairs: held point (first), new point (final)
    always_comb begin
        logic signed [33:0] pa, pb, off;
        for (int i = 0; i < 3; i++) begin
            pa  = 34'(r_held[i]);
            pb  = 34'(r_p[i]);
            off = 34'(r_off[i]);
            w_pair0[32*i +: 32]      = sat32(pa - off);
            w_pair0[96 + 32*i +: 32] = sat32(pa + off);
            w_pair1[32*i +: 32]      = sat32(pb - off);
            w_pair1[96 + 32*i +: 32] = sat32(pb + off);
        end
        w_pair0[223:192] = {1'b0, r_tex0};
        w_pair1[223:192] = {1'b0, r_tex1};
    end

    assign w_out_free = !r_ovalid || i_m_tready;

    // trail state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_path <= '0;
            for (int i = 0; i < 3; i++) r_held[i] <= '0;
        end else if (i_cmd.take && !r_seen) begin
            if (!i_tlast) begin
                r_seen <= 1'b1;
                for (int i = 0; i < 3; i++) r_held[i] <= i_tdata[32*i +: 32];
            end
            r_path <= '0;
        end else if (i_cmd.emit0 && !r_last) begin
            r_path <= r_plen1;
            for (int i = 0; i < 3; i++) r_held[i] <= r_p[i];
        end else if (i_cmd.emit1) begin
            r_seen <= 1'b0;
            r_path <= '0;
            for (int i = 0; i < 3; i++) r_held[i] <= '0;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_last <= i_tlast;
            for (int i = 0; i < 3; i++) r_p[i] <= i_tdata[32*i +: 32];
        end
        if (i_cmd.diff) begin
            for (int i = 0; i < 3; i++) r_d[i] <= 33'(r_p[i]) - 33'(r_held[i]);
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod[63:0];
        end
        if (i_cmd.acc) begin
            unique case (i_cmd.uop)
                UOP_CX_A:  r_c[0] <= r_prod[51:0];
                UOP_CX_B:  r_c[0] <= r_c[0] - r_prod[51:0];
                UOP_CY_A:  r_c[1] <= r_prod[51:0];
                UOP_CY_B:  r_c[1] <= r_c[1] - r_prod[51:0];
                UOP_CZ_A:  r_c[2] <= r_prod[51:0];
                UOP_CZ_B:  r_c[2] <= r_c[2] - r_prod[51:0];
                UOP_NSQ_X, UOP_SSQ_X: r_acc <= r_prod;
                UOP_NSQ_Y, UOP_NSQ_Z, UOP_SSQ_Y, UOP_SSQ_Z: r_acc <= r_acc + r_prod;
                UOP_NUM_X, UOP_NUM_Y, UOP_NUM_Z:
                    r_num <= r_prod[55:0] + {26'b0, r_len[30:1]};
                UOP_T0_LO, UOP_T1_LO: r_t <= r_prod;
                UOP_T0_HI: r_tex0 <= tex_sat(w_t_hi);
                UOP_T1_HI: r_tex1 <= tex_sat(w_t_hi);
                default: ;
            endcase
        end
        if (i_cmd.fix) begin
            // cross along the direction falls back to direction x z
            if (w_czero) begin
                r_m[0]   <= 51'(w_dmag[1]) << 16;
                r_neg[0] <= r_d[1][32];
                r_m[1]   <= 51'(w_dmag[0]) << 16;
                r_neg[1] <= (r_d[0] != '0) && !r_d[0][32];
                r_m[2]   <= '0;
                r_neg[2] <= 1'b0;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    r_m[i]   <= r_c[i][51] ? 51'(-r_c[i]) : 51'(r_c[i]);
                    r_neg[i] <= r_c[i][51];
                end
            end
            r_s <= w_s;
            for (int i = 0; i < 3; i++) r_ms[i] <= 31'(w_dmag[i] >> w_s);
        end
        if (i_cmd.norm) begin
            if (w_mzero) begin
                for (int i = 0; i < 3; i++) r_off[i] <= '0;
            end else if (w_any_hi) begin
                for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
            end else if (!w_any29) begin
                for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
            end
        end
        if (i_cmd.sq_take) begin
            if (i_cmd.uop == UOP_NSQ_Z) begin
                r_len <= w_root[30:0];
            end else begin
                r_plen1 <= w_plen[40] ? 40'hFF_FFFF_FFFF : w_plen[39:0];
            end
        end
        if (i_cmd.div_take) begin
            unique case (i_cmd.uop)
                UOP_NUM_X: r_off[0] <= r_neg[0] ? -27'(w_quo) : 27'(w_quo);
                UOP_NUM_Y: r_off[1] <= r_neg[1] ? -27'(w_quo) : 27'(w_quo);
                UOP_NUM_Z: r_off[2] <= r_neg[2] ? -27'(w_quo) : 27'(w_quo);
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit0 || i_cmd.emit1) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit0) begin
            r_odata <= w_pair0;
            r_olast <= 1'b0;
        end else if (i_cmd.emit1) begin
            r_odata <= w_pair1;
            r_olast <= 1'b1;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;

    always_comb begin
        o_status.seen      = r_seen;
        o_status.last      = r_last;
        o_status.norm_zero = w_mzero;
        o_status.norm_done = w_mzero || (!w_any_hi && w_any29);
        o_status.sq_busy   = w_sq_busy;
        o_status.div_busy  = w_div_busy;
        o_status.out_free  = w_out_free;
    end

endmodule

@@ rtl/prx_ctrl.sv @@
module prx_ctrl
    import prx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    input  t_status i_status,
    output logic    o_s_tready,
    output t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DIFF     = 4'd1;
    localparam logic [3:0] S_MUL      = 4'd2;
    localparam logic [3:0] S_ACC      = 4'd3;
    localparam logic [3:0] S_FIX      = 4'd4;
    localparam logic [3:0] S_NORM     = 4'd5;
    localparam logic [3:0] S_SQ_GO    = 4'd6;
    localparam logic [3:0] S_SQ_WAIT  = 4'd7;
    localparam logic [3:0] S_DIV_GO   = 4'd8;
    localparam logic [3:0] S_DIV_WAIT = 4'd9;
    localparam logic [3:0] S_EMIT0    = 4'd10;
    localparam logic [3:0] S_EMIT1    = 4'd11;

    logic [3:0] r_state, n_state;
    logic [4:0] r_uop, n_uop;

    always_comb begin
        n_state    = r_state;
        n_uop      = r_uop;
        o_cmd      = '0;
        o_cmd.uop  = r_uop;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.take = i_s_tvalid;
                if (i_s_tvalid && i_status.seen) begin
                    n_state = S_DIFF;
                    n_uop   = UOP_CX_A;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_MUL;
                n_uop     = r_uop + 1'b1;
                unique case (r_uop)
                    UOP_CZ_B:  n_state = S_FIX;
                    UOP_NSQ_Z, UOP_SSQ_Z: n_state = S_SQ_GO;
                    UOP_NUM_X, UOP_NUM_Y, UOP_NUM_Z: n_state = S_DIV_GO;
                    UOP_T1_HI: n_state = S_EMIT0;
                    default: ;
                endcase
                if (n_state != S_MUL) n_uop = r_uop;
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_NORM;
            end
            S_NORM: begin
                o_cmd.norm = 1'b1;
                if (i_status.norm_zero) begin
                    n_state = S_MUL;
                    n_uop   = UOP_SSQ_X;
                end else if (i_status.norm_done) begin
                    n_state = S_MUL;
                    n_uop   = UOP_NSQ_X;
                end
            end
            S_SQ_GO: begin
                o_cmd.sq_start = 1'b1;
                n_state        = S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
                if (!i_status.sq_busy) begin
                    o_cmd.sq_take = 1'b1;
                    n_state       = S_MUL;
                    n_uop         = (r_uop == UOP_NSQ_Z) ? UOP_NUM_X : UOP_T0_LO;
                end
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!i_status.div_busy) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_MUL;
                    n_uop          = (r_uop == UOP_NUM_Z) ? UOP_SSQ_X : r_uop + 1'b1;
                end
            end
            S_EMIT0: begin
                if (i_status.out_free) begin
                    o_cmd.emit0 = 1'b1;
                    n_state     = i_status.last ? S_EMIT1 : S_IDLE;
                end
            end
            S_EMIT1: begin
                if (i_status.out_free) begin
                    o_cmd.emit1 = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_uop   <= UOP_CX_A;
        end else begin
            r_state <= n_state;
            r_uop   <= n_uop;
        end
    end

endmodule

@@ rtl/polyline_ribbon_extruder.sv @@
// channel | dir | word contents (lowest bit up)
// s       | in  | tdata: point_x, point_y, point_z; tlast: end_of_trail
// m       | out | tdata: left_x/y/z, right_x/y/z, tex_v, pad; tlast: final_pair
// apb     | in  | regs at 0x00 up_x, 0x04 up_y, 0x08 up_z, 0x0C half_width, 0x10 anim_speed
//
// A first point of a trail is taken without leaving idle and gives no word.
// Any later point holds the input until it is done, output stalls aside: the shared
// square root unit runs twice, the divider once for each of three offsets, and the
// offset normalization shifts one bit a cycle (up to 29 shifts).
// A zero offset skips the first root and the divides; a final point adds a second emit.
// Reset (i_rst_n low at a clock edge) clears the trail and loads default registers.
// A word waiting in the output register holds the next emit, and the input with it.
module polyline_ribbon_extruder
    import prx_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [95:0]  i_s_tdata,   // point_x, point_y, point_z
    input  logic         i_s_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [223:0] o_m_tdata,   // left_x/y/z, right_x/y/z, tex_v, zero bit
    output logic         o_m_tlast,
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [4:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output logic [31:0]  o_prdata,
    output logic         o_pready
);

    t_cfg       r_cfg;
    t_cmd       w_cmd;
    t_status    w_status;
    logic [2:0] w_idx;
    logic       w_wr;

    assign o_pready = 1'b1;
    assign w_idx    = i_paddr[4:2];
    assign w_wr     = i_psel && i_penable && i_pwrite;

    // register file; writes beyond the list drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.up_x       <= '0;
            r_cfg.up_y       <= 18'sd65536;
            r_cfg.up_z       <= '0;
            r_cfg.half_width <= 25'd32768;
            r_cfg.anim_speed <= 24'd65536;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_UP_X: r_cfg.up_x       <= i_pwdata[17:0];
                REG_UP_Y: r_cfg.up_y       <= i_pwdata[17:0];
                REG_UP_Z: r_cfg.up_z       <= i_pwdata[17:0];
                REG_HALF: r_cfg.half_width <= i_pwdata[24:0];
                REG_ANIM: r_cfg.anim_speed <= i_pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_UP_X: o_prdata = {14'b0, r_cfg.up_x};
            REG_UP_Y: o_prdata = {14'b0, r_cfg.up_y};
            REG_UP_Z: o_prdata = {14'b0, r_cfg.up_z};
            REG_HALF: o_prdata = {7'b0, r_cfg.half_width};
            REG_ANIM: o_prdata = {8'b0, r_cfg.anim_speed};
            default:  o_prdata = '0;
        endcase
    end

    prx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_status   (w_status),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    prx_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_cfg      (r_cfg),
        .i_tdata    (i_s_tdata),
        .i_tlast    (i_s_tlast),
        .i_m_tready (i_m_tready),
        .o_status   (w_status),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

`ifndef ASSERT_OFF
    // the iterative units are idle whenever a new point may enter
    a_idle_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (!w_status.sq_busy && !w_status.div_busy))
        else $error("arith unit busy while input ready");

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // an emit never overwrites a word that is not taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit0 || w_cmd.emit1) |-> (!o_m_tvalid || i_m_tready))
        else $error("output word overwritten");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import prx_pkg::*;

    // one vertex pair as it leaves the block
    typedef struct packed {
        logic signed [31:0] lx;
        logic signed [31:0] ly;
        logic signed [31:0] lz;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic [30:0]        tex;
        logic               fin;
    } t_pair;

    // one row of the directed table; typed rows carry their pairs written out
    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        bit          last;
        bit          typed;
        int          n;
        t_pair       r0;
        t_pair       r1;
    } t_row;

    localparam int HOLD_CYCLES  = 2000;
    localparam int SETTLE_CYCLES = 300;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [95:0]  i_s_tdata;    // point_x, point_y, point_z
    logic         i_s_tlast;    // end_of_trail
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [223:0] o_m_tdata;    // left_x/y/z, right_x/y/z, tex_v, zero bit
    logic         o_m_tlast;    // final_pair
    logic         i_psel;
    logic         i_penable;
    logic         i_pwrite;
    logic [4:0]   i_paddr;
    logic [31:0]  i_pwdata;
    logic [31:0]  o_prdata;
    logic         o_pready;

    polyline_ribbon_extruder DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    // predictor copy of the registers and of the trail state
    logic signed [17:0] cfg_up_x   = 18'sd0;
    logic signed [17:0] cfg_up_y   = 18'sd65536;
    logic signed [17:0] cfg_up_z   = 18'sd0;
    logic [24:0]        cfg_half   = 25'd32768;
    logic [23:0]        cfg_speed  = 24'd65536;
    longint             held_pt[3] = '{0, 0, 0};
    bit [63:0]          trail_len  = 0;
    bit                 pt_held    = 0;

    t_pair pending_pairs[$];
    t_row  dir_rows[$];
    int    fail_count    = 0;
    int    send_idle_pct = 0;
    int    stall_pct     = 0;
    bit    hold_go       = 0;
    bit    hold_active   = 0;

    // extreme register settings, one phase each; random settings follow
    int cfg_rows[4][5] = '{
        '{0, 0, 0, 32768, 65536},
        '{65536, 0, 0, 16777216, 16777215},
        '{-65536, -65536, -65536, 0, 0},
        '{0, 0, 65536, 1, 1}
    };

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #24_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic bit [63:0] mag64(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic bit [63:0] root64(input bit [63:0] x);
        bit [63:0] r;
        bit [63:0] b;
        r = 0;
        b = 64'h1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] sat32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // segment length: scale down until every magnitude fits 31 bits, then root
    function automatic bit [63:0] seg_length(input longint d[3]);
        bit [63:0] m[3];
        bit [63:0] mx;
        bit [63:0] sum;
        int        s;
        mx = 0;
        sum = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag64(d[i]);
            if (m[i] > mx)
                mx = m[i];
        end
        while ((mx >> s) >= (64'h1 << 31))
            s++;
        for (int i = 0; i < 3; i++)
            sum += (m[i] >> s) * (m[i] >> s);
        return root64(sum) << s;
    endfunction

    // side offset: half width times the unit of direction cross up
    function automatic void side_offset(input longint d[3], output longint off[3]);
        longint    ux, uy, uz;
        longint    c[3];
        bit [63:0] m[3];
        bit [63:0] mx;
        bit [63:0] sum;
        bit [63:0] len;
        bit [63:0] q;
        ux = cfg_up_x;
        uy = cfg_up_y;
        uz = cfg_up_z;
        mx = 0;
        sum = 0;
        if (ux == 0 && uy == 0 && uz == 0)
            uy = 65536;
        c[0] = d[1] * uz - d[2] * uy;
        c[1] = d[2] * ux - d[0] * uz;
        c[2] = d[0] * uy - d[1] * ux;
        // direction along up: fall back to the z axis
        if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
            c[0] = d[1] * 65536;
            c[1] = -d[0] * 65536;
            c[2] = 0;
        end
        for (int i = 0; i < 3; i++) begin
            m[i] = mag64(c[i]);
            if (m[i] > mx)
                mx = m[i];
            off[i] = 0;
        end
        if (mx == 0)
            return;
        while (mx >= (64'h1 << 30)) begin
            for (int i = 0; i < 3; i++)
                m[i] >>= 1;
            mx >>= 1;
        end
        while (mx < (64'h1 << 29)) begin
            for (int i = 0; i < 3; i++)
                m[i] <<= 1;
            mx <<= 1;
        end
        for (int i = 0; i < 3; i++)
            sum += m[i] * m[i];
        len = root64(sum);
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * cfg_half + len / 2) / len;
            off[i] = c[i] < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic t_pair build_pair(input longint p[3], input longint off[3],
                                         input bit [63:0] plen, input bit fin);
        t_pair     r;
        bit [63:0] v;
        r.lx = sat32(p[0] - off[0]);
        r.ly = sat32(p[1] - off[1]);
        r.lz = sat32(p[2] - off[2]);
        r.rx = sat32(p[0] + off[0]);
        r.ry = sat32(p[1] + off[1]);
        r.rz = sat32(p[2] + off[2]);
        // path length times speed wraps at 64 bits, then rounds and saturates
        v = (plen * 64'(cfg_speed) + 64'd32768) >> 16;
        r.tex = v > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : v[30:0];
        r.fin = fin;
        return r;
    endfunction

    function automatic t_pair mk_pair(input int lx, ly, lz, rx, ry, rz, tex, input bit fin);
        return '{lx: lx, ly: ly, lz: lz, rx: rx, ry: ry, rz: rz, tex: tex[30:0], fin: fin};
    endfunction

    // advance the trail by one point; return the pairs it releases
    function automatic void extrude_point(input logic [31:0] px, py, pz, input bit last,
                                          output int n, output t_pair r0, output t_pair r1);
        longint    p[3];
        longint    d[3];
        longint    off[3];
        bit [63:0] nl;
        p[0] = longint'(signed'(px));
        p[1] = longint'(signed'(py));
        p[2] = longint'(signed'(pz));
        n = 0;
        r0 = '0;
        r1 = '0;
        if (!pt_held) begin
            // first point held; a lone last point leaves the trail empty
            if (!last) begin
                held_pt = p;
                pt_held = 1;
            end
            trail_len = 0;
            return;
        end
        for (int i = 0; i < 3; i++)
            d[i] = p[i] - held_pt[i];
        side_offset(d, off);
        r0 = build_pair(held_pt, off, trail_len, 1'b0);
        nl = trail_len + seg_length(d);
        if (nl > 64'hFF_FFFF_FFFF)
            nl = 64'hFF_FFFF_FFFF;
        if (last) begin
            r1 = build_pair(p, off, nl, 1'b1);
            held_pt = '{0, 0, 0};
            trail_len = 0;
            pt_held = 0;
            n = 2;
        end else begin
            held_pt = p;
            trail_len = nl;
            n = 1;
        end
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            REG_UP_X: cfg_up_x = val[17:0];
            REG_UP_Y: cfg_up_y = val[17:0];
            REG_UP_Z: cfg_up_z = val[17:0];
            REG_HALF: cfg_half = val[24:0];
            REG_ANIM: cfg_speed = val[23:0];
            default: ;
        endcase
    endfunction

    // setup cycle, access cycle; the register takes the value at the access edge
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= val;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        apply_reg(idx, val);
        @(posedge i_clk);
    endtask

    // offer one point, hold it until taken, then queue what it must produce
    task automatic send_point(input logic [31:0] px, py, pz, input bit last,
                              input bit typed, input int tn, input t_pair t0, t1);
        int    gap;
        int    n;
        t_pair r0;
        t_pair r1;
        gap = 0;
        while (gap < 200 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {pz, py, px};
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        extrude_point(px, py, pz, last, n, r0, r1);
        if (typed) begin
            n = tn;
            r0 = t0;
            r1 = t1;
        end
        if (n > 0)
            pending_pairs = {pending_pairs, r0};
        if (n > 1)
            pending_pairs = {pending_pairs, r1};
    endtask

    // drop valid, drain every pending pair, then let the block go quiet
    task automatic settle();
        i_s_tvalid <= 1'b0;
        wait (pending_pairs.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_point_coord(input logic [31:0] prev, input int kind);
        case (kind)
            0: return $urandom;
            1: return prev;
            default: return prev + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    // random trails: mostly well formed walks, with jumps, repeats and lone points
    task automatic run_trails(input int count);
        logic [31:0] p[3];
        int          len;
        int          kind;
        t_pair       nil;
        nil = '0;
        while (count > 0) begin
            len = $urandom_range(0, 9) == 0 ? 1 : $urandom_range(2, 10);
            if (len > count)
                len = count;
            for (int i = 0; i < 3; i++)
                p[i] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
            for (int k = 0; k < len; k++) begin
                if (k > 0) begin
                    kind = $urandom_range(0, 11);
                    for (int i = 0; i < 3; i++)
                        p[i] = rand_point_coord(p[i], kind == 0 ? 0 : (kind == 1 ? 1 : 2));
                    // now and then add -0x1_0000 in x and +0x1_0000 in z to the step
                    if (kind == 2) begin
                        p[0] = p[0] - 32'h1_0000;
                        p[2] = p[2] + 32'h1_0000;
                    end
                end
                send_point(p[0], p[1], p[2], k == len - 1, 1'b0, 0, nil, nil);
            end
            count -= len;
        end
    endtask

    // long receiver hold-off, counted here so the main flow keeps sending
    initial begin
        wait (hold_go);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active = 1'b0;
    end

    // compare each taken word with the oldest pending pair; pick next ready
    always @(posedge i_clk) begin
        t_pair got;
        t_pair want;
        if (o_m_tvalid && i_m_tready) begin
            got.lx  = o_m_tdata[31:0];
            got.ly  = o_m_tdata[63:32];
            got.lz  = o_m_tdata[95:64];
            got.rx  = o_m_tdata[127:96];
            got.ry  = o_m_tdata[159:128];
            got.rz  = o_m_tdata[191:160];
            got.tex = o_m_tdata[222:192];
            got.fin = o_m_tlast;
            if (pending_pairs.size() == 0) begin
                $display("%t: unexpected word %p", $time, got);
                fail_count++;
            end else begin
                want = pending_pairs.pop_front();
                if (got !== want) begin
                    $display("%t: mismatch expected %p actual %p", $time, want, got);
                    fail_count++;
                end
            end
        end
        if (!i_rst_n || hold_active)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= $urandom_range(99) >= stall_pct;
    end

    initial begin
        t_pair nil;
        t_row  rw;
        int    md;
        nil = '0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tlast  <= 1'b0;
        i_psel     <= 1'b0;
        i_penable  <= 1'b0;
        i_pwrite   <= 1'b0;
        i_paddr    <= '0;
        i_pwdata   <= '0;

        // directed table; defaults after reset: up (0,1,0), half 0.5, speed 1.0
        dir_rows = '{
            // first point of a trail: nothing out
            '{32'd0, 32'd0, 32'd0, 1'b0, 1'b1, 0, nil, nil},
            // unit step along x: offset points along z, both pairs out
            '{32'd65536, 32'd0, 32'd0, 1'b1, 1'b1, 2,
              mk_pair(0, 0, -32768, 0, 0, 32768, 0, 1'b0),
              mk_pair(65536, 0, -32768, 65536, 0, 32768, 65536, 1'b1)},
            // one-point trail
            '{32'd5, 32'd5, 32'd5, 1'b1, 1'b1, 0, nil, nil},
            '{32'd100, 32'd200, 32'd300, 1'b0, 1'b1, 0, nil, nil},
            // repeated point: zero offset
            '{32'd100, 32'd200, 32'd300, 1'b0, 1'b1, 1,
              mk_pair(100, 200, 300, 100, 200, 300, 0, 1'b0), nil},
            // along up: z fallback
            '{32'd100, 32'd65736, 32'd300, 1'b0, 1'b0, 0, nil, nil},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 0, nil, nil},
            '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, 0, nil, nil},
            '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 1'b0, 1'b0, 0, nil, nil},
            '{32'd0, 32'd0, 32'h7FFF_FFFF, 1'b1, 1'b0, 0, nil, nil},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 0, nil, nil},
            '{32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 0, nil, nil},
            '{32'd1, 32'd0, 32'd0, 1'b0, 1'b0, 0, nil, nil},
            '{32'hFFFF_0000, 32'h0001_0000, 32'd7, 1'b1, 1'b0, 0, nil, nil}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            rw = dir_rows[i];
            send_point(rw.x, rw.y, rw.z, rw.last, rw.typed, rw.n, rw.r0, rw.r1);
        end

        // random phases: new registers, new idling mode each time
        for (int ph = 0; ph < 10; ph++) begin
            settle();
            for (int r = 0; r < 5; r++) begin
                if (ph < 4)
                    write_reg(3'(r), cfg_rows[ph][r]);
                else if (r < 3)
                    write_reg(3'(r), $urandom_range(0, 3) == 0 ? 32'd0 : $urandom);
                else if (r == 3)
                    write_reg(REG_HALF, $urandom_range(0, 16777216));
                else
                    write_reg(REG_ANIM, $urandom);
            end
            md = ph % 4;
            send_idle_pct = md == 1 ? 81 : (md == 3 ? 7 : 0);
            stall_pct     = md == 2 ? 81 : (md == 3 ? 7 : 0);
            // fill the block against a stalled output once
            if (ph == 5)
                hold_go = 1'b1;
            run_trails(85);
        end

        settle();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
